@@ rtl/rwsp_pkg.sv @@
// Shared types, constants and codes for the RIFF/WAVE stream parser.
// No dependencies; every other file of the parser uses this package.
package rwsp_pkg;

    localparam int BYTE_W   = 8;
    localparam int EVENT_W  = 3;
    localparam int ERROR_W  = 3;
    localparam int TDATA_W  = 176;
    localparam int FMT_MIN  = 16;
    localparam int RIFF_MIN = 4;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [EVENT_W-1:0] EV_HEAD  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_AUDIO = 3'd1;
    localparam logic [EVENT_W-1:0] EV_FMT   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FIN   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_ERR   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_IGN   = 3'd5;

    localparam logic [ERROR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERROR_W-1:0] ERR_BAD_RIFF  = 3'd1;
    localparam logic [ERROR_W-1:0] ERR_BAD_SIZE  = 3'd2;
    localparam logic [ERROR_W-1:0] ERR_BAD_WAVE  = 3'd3;
    localparam logic [ERROR_W-1:0] ERR_TRUNCATED = 3'd4;
    localparam logic [ERROR_W-1:0] ERR_BAD_CHUNK = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              stream_last;
    } item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  audio_byte;
        logic               audio_last;
        logic [15:0]        format_tag;
        logic [15:0]        channels;
        logic [31:0]        sample_rate;
        logic [31:0]        avg_bytes_per_sec;
        logic [15:0]        block_align;
        logic [15:0]        bits_per_sample;
        logic [31:0]        data_length;
        logic [ERROR_W-1:0] error_code;
    } result_t;

endpackage

@@ rtl/rwsp_in_stage.sv @@
// Input register of the RIFF/WAVE stream parser: holds one byte transaction.
// Depends on rwsp_pkg.
module rwsp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rwsp_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output rwsp_pkg::item_t item
);

    logic            valid_reg;
    rwsp_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ rtl/rwsp_core.sv @@
// Parser state and per-byte decode of the RIFF/WAVE stream parser.
// Holds the header walk state and format fields; depends on rwsp_pkg.
module rwsp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  rwsp_pkg::item_t   item,
    output rwsp_pkg::result_t result
);

    typedef enum logic [3:0] {
        PH_RIFF, PH_SIZE, PH_WAVE, PH_CID, PH_CSIZE,
        PH_FMT, PH_DATA, PH_SKIP, PH_PEND, PH_DONE, PH_ERR
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER, KIND_FMT, KIND_DATA
    } kind_t;

    phase_t      phase_reg, phase_next;
    kind_t       kind_reg, kind_next;
    logic [31:0] field_reg, field_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] remain_reg, remain_next;
    logic [15:0] format_tag_reg, format_tag_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] sample_rate_reg, sample_rate_next;
    logic [31:0] byte_rate_reg, byte_rate_next;
    logic [15:0] block_align_reg, block_align_next;
    logic [15:0] sample_bits_reg, sample_bits_next;
    logic [31:0] data_length_reg, data_length_next;
    logic [2:0]  error_reg, error_next;

    logic [31:0] field_ins;
    logic [31:0] count_inc;
    logic [31:0] remain_dec;
    logic [2:0]  fail_code;
    logic        chunk_done;
    logic [2:0]  ev;
    logic [7:0]  abyte;
    logic        alast;
    logic [7:0]  b;

    assign b          = item.stream_byte;
    assign count_inc  = count_reg + 32'd1;
    assign remain_dec = remain_reg - 32'd1;
    assign field_ins  = ((count_reg[1:0] == 2'd0) ? 32'd0 : field_reg)
                      | ({24'd0, b} << {count_reg[1:0], 3'b000});

    always_comb begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        field_next       = field_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        format_tag_next  = format_tag_reg;
        channels_next    = channels_reg;
        sample_rate_next = sample_rate_reg;
        byte_rate_next   = byte_rate_reg;
        block_align_next = block_align_reg;
        sample_bits_next = sample_bits_reg;
        data_length_next = data_length_reg;
        error_next       = error_reg;
        fail_code        = rwsp_pkg::ERR_NONE;
        chunk_done       = 1'b0;
        ev               = rwsp_pkg::EV_HEAD;
        abyte            = 8'd0;
        alast            = 1'b0;

        if (step) begin
            if (phase_reg == PH_PEND) begin
                phase_next = PH_DONE;
                ev         = rwsp_pkg::EV_FIN;
            end else if (phase_reg == PH_DONE || phase_reg == PH_ERR) begin
                ev = rwsp_pkg::EV_IGN;
            end else begin
                remain_next = remain_dec;
                if (phase_reg == PH_RIFF || phase_reg == PH_SIZE || phase_reg == PH_WAVE
                        || phase_reg == PH_CID || phase_reg == PH_CSIZE) begin
                    field_next = field_ins;
                    count_next = count_inc;
                    if (count_reg[1:0] == 2'd3) begin
                        count_next = 32'd0;
                        unique case (phase_reg)
                            PH_RIFF: begin
                                if (field_ins != rwsp_pkg::ID_RIFF) begin
                                    fail_code = rwsp_pkg::ERR_BAD_RIFF;
                                end else begin
                                    phase_next = PH_SIZE;
                                end
                            end
                            PH_SIZE: begin
                                if (field_ins == 32'd0 || field_ins[31]) begin
                                    fail_code = rwsp_pkg::ERR_BAD_SIZE;
                                end else if (field_ins < 32'(rwsp_pkg::RIFF_MIN)) begin
                                    fail_code = rwsp_pkg::ERR_BAD_CHUNK;
                                end else begin
                                    remain_next = field_ins;
                                    phase_next  = PH_WAVE;
                                end
                            end
                            PH_WAVE: begin
                                if (field_ins != rwsp_pkg::ID_WAVE) begin
                                    fail_code = rwsp_pkg::ERR_BAD_WAVE;
                                end else begin
                                    chunk_done = 1'b1;
                                end
                            end
                            PH_CID: begin
                                if (field_ins == rwsp_pkg::ID_FMT) begin
                                    kind_next = KIND_FMT;
                                end else if (field_ins == rwsp_pkg::ID_DATA) begin
                                    kind_next = KIND_DATA;
                                end else begin
                                    kind_next = KIND_OTHER;
                                end
                                phase_next = PH_CSIZE;
                                if (remain_dec == 32'd0) begin
                                    fail_code = rwsp_pkg::ERR_BAD_CHUNK;
                                end
                            end
                            default: begin
                                if (field_ins > remain_dec) begin
                                    fail_code = rwsp_pkg::ERR_BAD_CHUNK;
                                end else if (kind_reg == KIND_FMT
                                        && field_ins < 32'(rwsp_pkg::FMT_MIN)) begin
                                    fail_code = rwsp_pkg::ERR_BAD_CHUNK;
                                end else begin
                                    if (kind_reg == KIND_DATA) begin
                                        data_length_next = field_ins;
                                    end
                                    if (field_ins == 32'd0) begin
                                        chunk_done = 1'b1;
                                    end else if (kind_reg == KIND_FMT) begin
                                        phase_next = PH_FMT;
                                    end else if (kind_reg == KIND_DATA) begin
                                        phase_next = PH_DATA;
                                    end else begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                            end
                        endcase
                    end else if ((phase_reg == PH_CID || phase_reg == PH_CSIZE)
                            && remain_dec == 32'd0) begin
                        fail_code = rwsp_pkg::ERR_BAD_CHUNK;
                    end
                end else begin
                    if (phase_reg == PH_FMT && count_reg[31:4] == 28'd0) begin
                        case (count_reg[3:0])
                            4'd0:  format_tag_next        = {8'd0, b};
                            4'd1:  format_tag_next[15:8]  = b;
                            4'd2:  channels_next          = {8'd0, b};
                            4'd3:  channels_next[15:8]    = b;
                            4'd4:  sample_rate_next       = {24'd0, b};
                            4'd5:  sample_rate_next[15:8] = b;
                            4'd6:  sample_rate_next[23:16] = b;
                            4'd7:  sample_rate_next[31:24] = b;
                            4'd8:  byte_rate_next         = {24'd0, b};
                            4'd9:  byte_rate_next[15:8]   = b;
                            4'd10: byte_rate_next[23:16]  = b;
                            4'd11: byte_rate_next[31:24]  = b;
                            4'd12: block_align_next       = {8'd0, b};
                            4'd13: block_align_next[15:8] = b;
                            4'd14: sample_bits_next       = {8'd0, b};
                            default: sample_bits_next[15:8] = b;
                        endcase
                        if (count_reg[3:0] == 4'd15) begin
                            ev = rwsp_pkg::EV_FMT;
                        end
                    end else if (phase_reg == PH_DATA) begin
                        ev    = rwsp_pkg::EV_AUDIO;
                        abyte = b;
                        alast = (count_inc == field_reg);
                    end
                    count_next = count_inc;
                    if (count_inc == field_reg) begin
                        chunk_done = 1'b1;
                    end
                end

                if (chunk_done) begin
                    count_next = 32'd0;
                    if (remain_dec == 32'd0) begin
                        if (ev == rwsp_pkg::EV_AUDIO) begin
                            phase_next = PH_PEND;
                        end else begin
                            phase_next = PH_DONE;
                            ev         = rwsp_pkg::EV_FIN;
                        end
                    end else begin
                        phase_next = PH_CID;
                    end
                end

                if (fail_code != rwsp_pkg::ERR_NONE) begin
                    error_next = fail_code;
                    phase_next = PH_ERR;
                    ev         = rwsp_pkg::EV_ERR;
                end

                if (item.stream_last && phase_next != PH_PEND && phase_next != PH_DONE
                        && phase_next != PH_ERR) begin
                    error_next = rwsp_pkg::ERR_TRUNCATED;
                    phase_next = PH_ERR;
                    ev         = rwsp_pkg::EV_ERR;
                end

                if (ev != rwsp_pkg::EV_AUDIO) begin
                    abyte = 8'd0;
                    alast = 1'b0;
                end
            end
        end
    end

    always_comb begin
        result.event_res         = ev;
        result.audio_byte        = abyte;
        result.audio_last        = alast;
        result.format_tag        = format_tag_next;
        result.channels          = channels_next;
        result.sample_rate       = sample_rate_next;
        result.avg_bytes_per_sec = byte_rate_next;
        result.block_align       = block_align_next;
        result.bits_per_sample   = sample_bits_next;
        result.data_length       = data_length_next;
        result.error_code        = error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_RIFF;
            kind_reg        <= KIND_OTHER;
            field_reg       <= 32'd0;
            count_reg       <= 32'd0;
            remain_reg      <= 32'd0;
            format_tag_reg  <= 16'd0;
            channels_reg    <= 16'd0;
            sample_rate_reg <= 32'd0;
            byte_rate_reg   <= 32'd0;
            block_align_reg <= 16'd0;
            sample_bits_reg <= 16'd0;
            data_length_reg <= 32'd0;
            error_reg       <= 3'd0;
        end else begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            field_reg       <= field_next;
            count_reg       <= count_next;
            remain_reg      <= remain_next;
            format_tag_reg  <= format_tag_next;
            channels_reg    <= channels_next;
            sample_rate_reg <= sample_rate_next;
            byte_rate_reg   <= byte_rate_next;
            block_align_reg <= block_align_next;
            sample_bits_reg <= sample_bits_next;
            data_length_reg <= data_length_next;
            error_reg       <= error_next;
        end
    end

endmodule

@@ rtl/rwsp_out_stage.sv @@
// Result register of the RIFF/WAVE stream parser: holds one result transaction.
// Depends on rwsp_pkg.
module rwsp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_valid,
    input  rwsp_pkg::result_t load_result,
    output logic              load_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rwsp_pkg::result_t m_result
);

    logic              valid_reg;
    rwsp_pkg::result_t result_reg;

    assign load_ready = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_result   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load_valid;
        end
        if (load_ready && load_valid) begin
            result_reg <= load_result;
        end
    end

endmodule

@@ rtl/riff_wave_stream_parser.sv @@
// RIFF/WAVE stream parser top level: one byte in, one result transaction out.
// A byte is registered in the input stage, then its result in the result register.
// Throughput is one byte per cycle, set by the two registers, unless m_tready stalls.
// Reset is synchronous and active low; it clears the parser state and format fields.
// Depends on rwsp_pkg, rwsp_in_stage, rwsp_core and rwsp_out_stage.
module riff_wave_stream_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // stream_byte
    input  logic                          s_tlast,  // stream_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // audio_byte, format_tag, channels, sample_rate, avg_bytes_per_sec,
    // block_align, bits_per_sample, data_length, error_code, zero fill
    output logic [rwsp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast,  // audio_last
    output logic [rwsp_pkg::EVENT_W-1:0]  m_tuser   // event_res
);

    rwsp_pkg::item_t   s_item;
    rwsp_pkg::item_t   item;
    rwsp_pkg::result_t step_result;
    rwsp_pkg::result_t m_result;
    logic              item_valid;
    logic              load_ready;

    assign s_item.stream_byte = s_tdata;
    assign s_item.stream_last = s_tlast;

    rwsp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (load_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    rwsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (item_valid && load_ready),
        .item    (item),
        .result  (step_result)
    );

    rwsp_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (item_valid),
        .load_result (step_result),
        .load_ready  (load_ready),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = {5'd0,
                      m_result.error_code,
                      m_result.data_length,
                      m_result.bits_per_sample,
                      m_result.block_align,
                      m_result.avg_bytes_per_sec,
                      m_result.sample_rate,
                      m_result.channels,
                      m_result.format_tag,
                      m_result.audio_byte};
    assign m_tlast = m_result.audio_last;
    assign m_tuser = m_result.event_res;

endmodule
